[src/tlex_pkg.sv]
package tlex_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] ChMinus     = 8'h2d;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChUnder     = 8'h5f;
  localparam logic [7:0] ChNewline   = 8'h0a;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_KEY  = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_TEXT = 3'd3,
    MODE_ESC  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    KIND_KEY   = 3'd0,
    KIND_NUM   = 3'd1,
    KIND_TEXT  = 3'd2,
    KIND_NL    = 3'd3,
    KIND_EMPTY = 3'd4,
    KIND_ERR   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ESCAPE   = 2'd1,
    ERR_UNTERM   = 2'd2
  } err_e;

  // one result as it leaves the block
  typedef struct packed {
    kind_e      kind;
    logic       char_valid;
    logic [7:0] ch;
    logic       last;
    err_e       err;
  } res_t;

  // what one item leaves for the back end: one or two results
  typedef struct packed {
    res_t first;
    res_t second;
    logic two;
  } cmd_t;

  function automatic logic is_letter(input logic [7:0] b);
    is_letter = (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic res_t mk_res(input kind_e kind, input logic cv, input logic [7:0] ch,
                                  input logic last, input err_e err);
    res_t r;
    r.kind       = kind;
    r.char_valid = cv;
    r.ch         = cv ? ch : 8'h00;
    r.last       = last;
    r.err        = err;
    mk_res = r;
  endfunction

endpackage

[src/token_lexer.sv]
// streaming tokenizer: one ascii byte or an end-of-input mark per input transfer,
// one token character or token event per output transfer
// input channel: in_valid_i/in_ready_i with in_byte_i and end_of_input_i
// output channel: out_valid_o/out_ready_i with kind, char, last, error and run_last
// front end runs the lexer mode register and turns each byte into zero, one or
// two results, pushed as one entry into a small command queue
// back end pops the queue and presents one result per cycle from an output register
// while the queue holds entries and the receiver keeps taking them
// a result enters the command queue with its input transfer and the output register
// once that register is free; throughput: one byte per cycle while results are single
// and the queue has room; a byte that closes a token and starts another gives two
// results, sent in turn through the single output register in the back end; skipped
// bytes, opening quotes and backslashes in text give no result and never enter the queue
// in_ready_o drops only while the command queue is full
// reset puts the lexer in idle and empties the queue and the output register
// a stalled receiver holds the output register; the queue takes QueueDepth more
// result entries, bytes without a result keep flowing, and once it is full the
// input side is held off
module token_lexer #(
  parameter int unsigned QueueDepth = tlex_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] token_kind_o,
  output logic       char_valid_o,
  output logic [7:0] out_char_o,
  output logic       token_last_o,
  output logic [1:0] error_code_o,
  output logic       run_last_o
);
  import tlex_pkg::*;

  logic accept;
  logic push, full, pop, empty;
  cmd_t push_cmd, head;
  res_t res;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  // front: mode register and classification
  tlex_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  // decouples classification from the output stalls
  tlex_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  // back: splits each entry into its results
  tlex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .run_last_o  (run_last_o)
  );

  assign token_kind_o = res.kind;
  assign char_valid_o = res.char_valid;
  assign out_char_o   = res.ch;
  assign token_last_o = res.last;
  assign error_code_o = res.err;

endmodule

[src/tlex_front.sv]
module tlex_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_input_i,
  output logic          push_o,
  output tlex_pkg::cmd_t cmd_o
);
  import tlex_pkg::*;

  mode_e mode_q, mode_d;

  // next state from the idle view of a byte
  function automatic mode_e idle_mode(input logic [7:0] b);
    if (is_letter(b))                      idle_mode = MODE_KEY;
    else if (b == ChMinus || is_digit(b))  idle_mode = MODE_NUM;
    else if (b == ChQuote)                 idle_mode = MODE_TEXT;
    else                                   idle_mode = MODE_IDLE;
  endfunction

  // result, if any, of a byte seen from idle
  function automatic logic idle_emits(input logic [7:0] b);
    idle_emits = is_letter(b) || is_digit(b) || b == ChMinus || b == ChNewline;
  endfunction

  function automatic res_t idle_res(input logic [7:0] b);
    if (is_letter(b))                      idle_res = mk_res(KIND_KEY, 1'b1, b, 1'b0, ERR_NONE);
    else if (b == ChMinus || is_digit(b))  idle_res = mk_res(KIND_NUM, 1'b1, b, 1'b0, ERR_NONE);
    else                                   idle_res = mk_res(KIND_NL, 1'b0, b, 1'b1, ERR_NONE);
  endfunction

  logic key_cont, num_cont;
  assign key_cont = is_letter(in_byte_i) || is_digit(in_byte_i) || in_byte_i == ChUnder;
  assign num_cont = is_digit(in_byte_i);

  // next state
  always_comb begin
    mode_d = mode_q;
    if (end_of_input_i) begin
      mode_d = MODE_IDLE;
    end else begin
      unique case (mode_q)
        MODE_KEY:  if (!key_cont) mode_d = idle_mode(in_byte_i);
        MODE_NUM:  if (!num_cont) mode_d = idle_mode(in_byte_i);
        MODE_TEXT: begin
          if (in_byte_i == ChQuote)          mode_d = MODE_IDLE;
          else if (in_byte_i == ChBackslash) mode_d = MODE_ESC;
        end
        MODE_ESC: begin
          if (in_byte_i == ChQuote || in_byte_i == ChBackslash) mode_d = MODE_TEXT;
          else                                                  mode_d = MODE_IDLE;
        end
        default:   mode_d = idle_mode(in_byte_i);
      endcase
    end
  end

  // results
  always_comb begin
    push_o       = 1'b0;
    cmd_o.two    = 1'b0;
    cmd_o.first  = mk_res(KIND_EMPTY, 1'b0, 8'h00, 1'b1, ERR_NONE);
    cmd_o.second = mk_res(KIND_EMPTY, 1'b0, 8'h00, 1'b1, ERR_NONE);
    if (end_of_input_i) begin
      push_o = 1'b1;
      unique case (mode_q)
        MODE_KEY: begin
          cmd_o.first = mk_res(KIND_KEY, 1'b0, 8'h00, 1'b1, ERR_NONE);
          cmd_o.two   = 1'b1;
        end
        MODE_NUM: begin
          cmd_o.first = mk_res(KIND_NUM, 1'b0, 8'h00, 1'b1, ERR_NONE);
          cmd_o.two   = 1'b1;
        end
        MODE_TEXT, MODE_ESC: cmd_o.first = mk_res(KIND_ERR, 1'b0, 8'h00, 1'b1, ERR_UNTERM);
        default:             cmd_o.first = mk_res(KIND_EMPTY, 1'b0, 8'h00, 1'b1, ERR_NONE);
      endcase
    end else begin
      unique case (mode_q)
        MODE_KEY, MODE_NUM: begin
          push_o = 1'b1;
          if ((mode_q == MODE_KEY) ? key_cont : num_cont) begin
            cmd_o.first = mk_res((mode_q == MODE_KEY) ? KIND_KEY : KIND_NUM,
                                 1'b1, in_byte_i, 1'b0, ERR_NONE);
          end else begin
            // close the token, then treat the byte as if from idle
            cmd_o.first  = mk_res((mode_q == MODE_KEY) ? KIND_KEY : KIND_NUM,
                                  1'b0, 8'h00, 1'b1, ERR_NONE);
            cmd_o.second = idle_res(in_byte_i);
            cmd_o.two    = idle_emits(in_byte_i);
          end
        end
        MODE_TEXT: begin
          if (in_byte_i == ChQuote) begin
            push_o      = 1'b1;
            cmd_o.first = mk_res(KIND_TEXT, 1'b0, 8'h00, 1'b1, ERR_NONE);
          end else if (in_byte_i != ChBackslash) begin
            push_o      = 1'b1;
            cmd_o.first = mk_res(KIND_TEXT, 1'b1, in_byte_i, 1'b0, ERR_NONE);
          end
        end
        MODE_ESC: begin
          push_o = 1'b1;
          if (in_byte_i == ChQuote || in_byte_i == ChBackslash) begin
            cmd_o.first = mk_res(KIND_TEXT, 1'b1, in_byte_i, 1'b0, ERR_NONE);
          end else begin
            cmd_o.first = mk_res(KIND_ERR, 1'b0, 8'h00, 1'b1, ERR_ESCAPE);
          end
        end
        default: begin
          push_o      = idle_emits(in_byte_i);
          cmd_o.first = idle_res(in_byte_i);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (accept_i) begin
      mode_q <= mode_d;
    end
  end

endmodule

[src/tlex_queue.sv]
module tlex_queue #(
  parameter int unsigned Depth = tlex_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tlex_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tlex_pkg::cmd_t head_o
);
  import tlex_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop)      count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

[src/tlex_back.sv]
module tlex_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  tlex_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tlex_pkg::res_t res_o,
  output logic           run_last_o
);
  import tlex_pkg::*;

  logic sel_q, sel_d;
  logic valid_q, valid_d;
  res_t res_q;
  logic run_last_q;
  logic load, cmd_done;
  res_t pick;

  assign load     = !empty_i && (!valid_q || out_ready_i);
  assign pick     = sel_q ? head_i.second : head_i.first;
  assign cmd_done = sel_q || !head_i.two;
  assign pop_o    = load && cmd_done;

  always_comb begin
    sel_d   = sel_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      sel_d   = !cmd_done;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      sel_q   <= sel_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q      <= pick;
      run_last_q <= cmd_done;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;
  assign run_last_o  = run_last_q;

endmodule
